@@ rtl/assert_macros.svh @@
// Assertion macros for the access check engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ rtl/acl_pkg.sv @@
package acl_pkg;
   localparam int AclEntriesDef  = 16;
   localparam int TokenGroupsDef = 8;
   localparam int MaxSubsDef     = 8;
   localparam int InSubs         = 8;
   localparam int HeadW          = 44;
   localparam int ReqDataW       = 336;
   localparam int RspDataW       = 8;

   typedef enum logic [2:0] {
      REQ_ADD_ENTRY = 3'd0,
      REQ_CHECK     = 3'd1,
      REQ_IMPERSON  = 3'd2,
      REQ_REVERT    = 3'd3,
      REQ_ADD_GROUP = 3'd4,
      REQ_SET_USER  = 3'd5,
      REQ_CLEAR     = 3'd6,
      REQ_NONE      = 3'd7
   } req_code_type;

   // default token identifiers
   localparam logic [HeadW-1:0] DefHead  = {8'd1, 4'd1, 32'd5};
   localparam logic [31:0]      UserSub0 = 32'd1000;
   localparam logic [31:0]      GroupSub0 = 32'd513;
endpackage

@@ rtl/acl_access_check_engine.sv @@
// Access check engine. The entry table (allow bit, rights mask, identifier
// head and sub-values) sits in one synchronous memory of one row per entry.
// A check walks the table, one row per cycle behind a registered read,
// comparing each row against the effective user and all groups at once;
// every other request is answered straight from the idle state. One item
// is in work at a time; the result waits in an output register and the
// next item is taken as soon as it is free.
`include "assert_macros.svh"
module acl_access_check_engine #(
   parameter int ACL_ENTRIES  = acl_pkg::AclEntriesDef,
   parameter int TOKEN_GROUPS = acl_pkg::TokenGroupsDef,
   parameter int MAX_SUBS     = acl_pkg::MaxSubsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // req_type[2:0], sid_revision[10:3], sid_sub_count[14:11],
   // sid_authority[46:15], sid_subs_01..67[302:47], allow_entry[303],
   // access_mask[335:304]
   input  logic [acl_pkg::ReqDataW-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status[0], granted[1], zeros above
   output logic [acl_pkg::RspDataW-1:0]  rsp_tdata
);
   import acl_pkg::*;

   localparam int IdxW  = (ACL_ENTRIES > 1) ? $clog2(ACL_ENTRIES) : 1;
   localparam int CntW  = $clog2(ACL_ENTRIES + 1);
   localparam int GCntW = $clog2(TOKEN_GROUPS + 1);
   localparam int GIdxW = (TOKEN_GROUPS > 1) ? $clog2(TOKEN_GROUPS) : 1;
   localparam int SubsW = 32 * MAX_SUBS;
   localparam int RowW  = 1 + 32 + HeadW + SubsW;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   // unpack the request
   logic [2:0]       f_type;
   logic [HeadW-1:0] f_head;
   logic [SubsW-1:0] f_subs;
   logic             f_allow;
   logic [31:0]      f_mask;
   assign f_type  = req_tdata[2:0];
   assign f_head  = {req_tdata[10:3], req_tdata[14:11], req_tdata[46:15]};
   assign f_allow = req_tdata[303];
   assign f_mask  = req_tdata[335:304];
   always_comb begin
      for (int i = 0; i < MAX_SUBS; i++) begin
         if (i < InSubs) f_subs[32*i +: 32] = req_tdata[47 + 32*i +: 32];
         else            f_subs[32*i +: 32] = '0;
      end
   end

   // identifier equality: head equal, then first min(count, MAX_SUBS) subs
   function automatic logic sid_eq(logic [HeadW-1:0] ha, logic [SubsW-1:0] sa,
                                   logic [HeadW-1:0] hb, logic [SubsW-1:0] sb);
      logic r;
      r = (ha == hb);
      for (int i = 0; i < MAX_SUBS; i++)
         if (32'(i) < 32'(ha[35:32]) && sa[32*i +: 32] != sb[32*i +: 32]) r = 1'b0;
      return r;
   endfunction

   // entry table memory
   logic [RowW-1:0] tbl_mem [ACL_ENTRIES];
   logic [RowW-1:0] rd_row_ff;
   logic [IdxW-1:0] rd_addr;
   logic            wr_en;

   // token registers
   logic [HeadW-1:0] user_head_ff, imp_head_ff;
   logic [SubsW-1:0] user_subs_ff, imp_subs_ff;
   logic             imp_ff;
   logic [HeadW-1:0] grp_head_ff [TOKEN_GROUPS];
   logic [SubsW-1:0] grp_subs_ff [TOKEN_GROUPS];
   logic [GCntW-1:0] grp_cnt_ff;
   logic [CntW-1:0]  acl_cnt_ff;

   // control
   state_type        state_ff;
   logic [CntW-1:0]  scan_ff;
   logic             rd_vld_ff;
   logic [31:0]      mask_ff;
   logic             allow_ff, deny_ff;
   logic             rsp_vld_ff, status_ff, granted_ff;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_vld_ff;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RspDataW-2){1'b0}}, granted_ff, status_ff};

   logic acc;
   assign acc   = req_tvalid && req_tready;
   assign wr_en = acc && f_type == REQ_ADD_ENTRY && acl_cnt_ff < CntW'(ACL_ENTRIES);
   assign rd_addr = scan_ff[IdxW-1:0];

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) tbl_mem[acl_cnt_ff[IdxW-1:0]] <= {f_allow, f_mask, f_head, f_subs};
      rd_row_ff <= tbl_mem[rd_addr];
   end

   // compare the row read against the token
   logic             row_allow, row_match, row_cover;
   logic [31:0]      row_mask;
   logic [HeadW-1:0] row_head;
   logic [SubsW-1:0] row_subs;
   assign {row_allow, row_mask, row_head, row_subs} = rd_row_ff;
   always_comb begin
      row_match = imp_ff ? sid_eq(imp_head_ff, imp_subs_ff, row_head, row_subs)
                         : sid_eq(user_head_ff, user_subs_ff, row_head, row_subs);
      for (int g = 0; g < TOKEN_GROUPS; g++)
         if (GCntW'(g) < grp_cnt_ff && sid_eq(grp_head_ff[g], grp_subs_ff[g],
                                               row_head, row_subs))
            row_match = 1'b1;
      row_cover = ((row_mask & mask_ff) == mask_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_vld_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         scan_ff      <= '0;
         acl_cnt_ff   <= '0;
         grp_cnt_ff   <= GCntW'(1);
         imp_ff       <= 1'b0;
         user_head_ff <= DefHead;
         user_subs_ff <= SubsW'(UserSub0);
         imp_head_ff  <= '0;
         imp_subs_ff  <= '0;
         for (int g = 0; g < TOKEN_GROUPS; g++) begin
            grp_head_ff[g] <= (g == 0) ? DefHead : '0;
            grp_subs_ff[g] <= (g == 0) ? SubsW'(GroupSub0) : '0;
         end
      end else begin
         if (rsp_vld_ff && rsp_tready) rsp_vld_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  status_ff  <= (f_type == REQ_ADD_ENTRY && !wr_en) ||
                                (f_type == REQ_ADD_GROUP &&
                                 grp_cnt_ff >= GCntW'(TOKEN_GROUPS));
                  granted_ff <= 1'b0;
                  case (f_type)
                     REQ_ADD_ENTRY: begin
                        if (wr_en) acl_cnt_ff <= acl_cnt_ff + 1'b1;
                        rsp_vld_ff <= 1'b1;
                     end
                     REQ_CHECK: begin
                        mask_ff   <= f_mask;
                        allow_ff  <= 1'b0;
                        deny_ff   <= 1'b0;
                        scan_ff   <= '0;
                        rd_vld_ff <= 1'b0;
                        state_ff  <= ST_SCAN;
                     end
                     REQ_IMPERSON: begin
                        imp_head_ff <= f_head;
                        imp_subs_ff <= f_subs;
                        imp_ff      <= 1'b1;
                        rsp_vld_ff  <= 1'b1;
                     end
                     REQ_REVERT: begin
                        imp_head_ff <= '0;
                        imp_subs_ff <= '0;
                        imp_ff      <= 1'b0;
                        rsp_vld_ff  <= 1'b1;
                     end
                     REQ_ADD_GROUP: begin
                        if (grp_cnt_ff < GCntW'(TOKEN_GROUPS)) begin
                           grp_head_ff[grp_cnt_ff[GIdxW-1:0]] <= f_head;
                           grp_subs_ff[grp_cnt_ff[GIdxW-1:0]] <= f_subs;
                           grp_cnt_ff <= grp_cnt_ff + 1'b1;
                        end
                        rsp_vld_ff <= 1'b1;
                     end
                     REQ_SET_USER: begin
                        user_head_ff <= f_head;
                        user_subs_ff <= f_subs;
                        rsp_vld_ff   <= 1'b1;
                     end
                     REQ_CLEAR: begin
                        acl_cnt_ff <= '0;
                        rsp_vld_ff <= 1'b1;
                     end
                     default: rsp_vld_ff <= 1'b1;
                  endcase
               end
            end
            ST_SCAN: begin
               // fold in the row read last cycle, advance the address
               if (rd_vld_ff && row_match && row_cover) begin
                  if (row_allow) allow_ff <= 1'b1;
                  else           deny_ff  <= 1'b1;
               end
               if (scan_ff < acl_cnt_ff) begin
                  scan_ff   <= scan_ff + 1'b1;
                  rd_vld_ff <= 1'b1;
               end else begin
                  rd_vld_ff <= 1'b0;
                  state_ff  <= ST_DONE;
               end
            end
            ST_DONE: begin
               granted_ff <= allow_ff && !deny_ff;
               rsp_vld_ff <= 1'b1;
               state_ff   <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLIES(a_cnt_range, clock, reset, 1'b1, acl_cnt_ff <= CntW'(ACL_ENTRIES))
   `ASSERT_IMPLIES(a_grp_range, clock, reset, 1'b1, grp_cnt_ff >= GCntW'(1) && grp_cnt_ff <= GCntW'(TOKEN_GROUPS))
   `ASSERT_IMPLIES(a_no_rsp_in_scan, clock, reset, state_ff == ST_SCAN, !rsp_vld_ff)
   `ASSERT_IMPLIES(a_grant_check, clock, reset, rsp_vld_ff && granted_ff, !status_ff)
endmodule

@@ test/acl_access_check_engine_test.sv @@
module acl_access_check_engine_test;
   import acl_pkg::*;

   localparam int NumEntries = 16;
   localparam int NumGroups  = 8;
   localparam int NumSubs    = 8;
   localparam int CycleLimit = 1500000;

   typedef struct packed {
      logic [7:0]  rev;
      logic [3:0]  cnt;
      logic [31:0] auth;
   } sid_head_type;

   typedef struct {
      sid_head_type head;
      logic [31:0]  subs [NumSubs];
   } sid_type;

   typedef struct {
      req_code_type code;
      sid_type      sid;
      logic         allow;
      logic [31:0]  mask;
   } access_req_type;

   typedef struct packed {
      logic status;
      logic granted;
   } verdict_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;

   acl_access_check_engine u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // shadow token and table
   int          tbl_count;
   logic        tbl_allow [NumEntries];
   logic [31:0] tbl_mask  [NumEntries];
   sid_type     tbl_sid   [NumEntries];
   sid_type     user_sid;
   sid_type     imp_sid;
   logic        imp_on;
   int          grp_count;
   sid_type     grp_sid [NumGroups];

   verdict_type pending_verdicts [$];
   int          errors;
   int          cycles;
   int          accepted;
   int          sub_pool [4];

   initial begin
      clock = 1'b0;
   end
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic sid_type default_sid(logic [31:0] sub0);
      sid_type s;
      s.head = {8'd1, 4'd1, 32'd5};
      for (int i = 0; i < NumSubs; i++) s.subs[i] = '0;
      s.subs[0] = sub0;
      return s;
   endfunction

   function automatic bit sid_same(sid_type a, sid_type b);
      if (a.head != b.head) return 1'b0;
      for (int i = 0; i < a.head.cnt && i < NumSubs; i++)
         if (a.subs[i] != b.subs[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit held_by_token(sid_type s);
      if (sid_same(imp_on ? imp_sid : user_sid, s)) return 1'b1;
      for (int g = 0; g < grp_count; g++)
         if (sid_same(grp_sid[g], s)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void reset_token();
      tbl_count = 0;
      user_sid  = default_sid(UserSub0);
      imp_sid   = default_sid(32'd0);
      imp_sid.head = '0;
      imp_on    = 1'b0;
      grp_count = 1;
      grp_sid[0] = default_sid(GroupSub0);
   endfunction

   // apply one request to the shadow state and return its verdict
   function automatic verdict_type apply_request(access_req_type r);
      verdict_type v;
      bit allowed, denied;
      v = '0;
      allowed = 1'b0;
      denied  = 1'b0;
      case (r.code)
         REQ_ADD_ENTRY: begin
            if (tbl_count >= NumEntries) v.status = 1'b1;
            else begin
               tbl_allow[tbl_count] = r.allow;
               tbl_mask[tbl_count]  = r.mask;
               tbl_sid[tbl_count]   = r.sid;
               tbl_count++;
            end
         end
         REQ_CHECK: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (held_by_token(tbl_sid[i]) && ((tbl_mask[i] & r.mask) == r.mask)) begin
                  if (tbl_allow[i]) allowed = 1'b1;
                  else denied = 1'b1;
               end
            end
            v.granted = allowed && !denied;
         end
         REQ_IMPERSON: begin
            imp_sid = r.sid;
            imp_on  = 1'b1;
         end
         REQ_REVERT: begin
            imp_on = 1'b0;
            imp_sid.head = '0;
            for (int i = 0; i < NumSubs; i++) imp_sid.subs[i] = '0;
         end
         REQ_ADD_GROUP: begin
            if (grp_count >= NumGroups) v.status = 1'b1;
            else begin
               grp_sid[grp_count] = r.sid;
               grp_count++;
            end
         end
         REQ_SET_USER: user_sid = r.sid;
         REQ_CLEAR: tbl_count = 0;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [ReqDataW-1:0] pack_request(access_req_type r);
      logic [ReqDataW-1:0] d;
      d = '0;
      d[2:0]   = r.code;
      d[10:3]  = r.sid.head.rev;
      d[14:11] = r.sid.head.cnt;
      d[46:15] = r.sid.head.auth;
      for (int i = 0; i < NumSubs; i++) d[47 + 32*i +: 32] = r.sid.subs[i];
      d[303]     = r.allow;
      d[335:304] = r.mask;
      return d;
   endfunction

   // identifier drawn mostly from a small pool so matches are common
   function automatic sid_type pick_sid();
      sid_type s;
      int k;
      k = $urandom_range(0, 9);
      if (k < 3) return default_sid(UserSub0);
      if (k < 5) return default_sid(GroupSub0);
      if (k < 8) begin
         s = default_sid(sub_pool[$urandom_range(0, 3)]);
         s.head.cnt = 4'($urandom_range(1, 2));
         s.subs[1] = 32'h77;
         for (int i = 2; i < NumSubs; i++) s.subs[i] = $urandom;
         return s;
      end
      s.head.rev  = 8'($urandom);
      s.head.cnt  = 4'($urandom_range(0, 15));
      s.head.auth = $urandom;
      for (int i = 0; i < NumSubs; i++) s.subs[i] = $urandom;
      return s;
   endfunction

   function automatic logic [31:0] pick_mask();
      case ($urandom_range(0, 4))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h1 << $urandom_range(0, 31);
         3: return $urandom & 32'h0000_00FF;
         default: return $urandom;
      endcase
   endfunction

   function automatic access_req_type random_request();
      access_req_type r;
      int k;
      k = $urandom_range(0, 99);
      if (k < 25)      r.code = REQ_ADD_ENTRY;
      else if (k < 75) r.code = REQ_CHECK;
      else if (k < 80) r.code = REQ_IMPERSON;
      else if (k < 84) r.code = REQ_REVERT;
      else if (k < 89) r.code = REQ_ADD_GROUP;
      else if (k < 93) r.code = REQ_SET_USER;
      else if (k < 98) r.code = REQ_CLEAR;
      else             r.code = REQ_NONE;
      r.sid   = pick_sid();
      r.allow = ($urandom_range(0, 3) != 0);
      r.mask  = pick_mask();
      return r;
   endfunction

   // offer one item after a random gap and log its verdict; valid stays
   // high after the accepting edge so a zero gap runs back to back
   task automatic send_request(access_req_type r, bit use_table, verdict_type typed);
      int gap;
      verdict_type v;
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= pack_request(r);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      v = apply_request(r);
      if (use_table && v != typed) begin
         $display("%0t directed row mispredicted: expected %b got %b", $time, typed, v);
         errors++;
      end
      pending_verdicts.push_back(v);
      accepted++;
   endtask

   // result side: compare against the oldest verdict, then a random stall
   initial begin
      verdict_type want;
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t unexpected result: expected none got %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tdata[0] !== want.status) begin
                  $display("%0t status mismatch: expected %b got %b",
                           $time, want.status, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[1] !== want.granted) begin
                  $display("%0t granted mismatch: expected %b got %b",
                           $time, want.granted, rsp_tdata[1]);
                  errors++;
               end
               if (rsp_tdata[RspDataW-1:2] !== '0) begin
                  $display("%0t padding mismatch: expected 0 got %h",
                           $time, rsp_tdata[RspDataW-1:2]);
                  errors++;
               end
            end
            stall = $urandom_range(0, 17);
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end else if (!rsp_tready) begin
            if ($urandom_range(0, 3) == 0) rsp_tready <= 1'b1;
         end
      end
   end

   typedef struct {
      req_code_type code;
      int           sid_kind;   // 0 user, 1 group, 2 all-ones, 3 all-zero
      logic         allow;
      logic [31:0]  mask;
      bit           typed;
      verdict_type  want;
   } stim_row_type;

   stim_row_type rows [] = '{
      '{REQ_CHECK,     0, 1'b1, 32'h0000_0001, 1, 2'b00},  // empty table denies
      '{REQ_NONE,      0, 1'b1, 32'hFFFF_FFFF, 1, 2'b00},  // unused code
      '{REQ_ADD_ENTRY, 0, 1'b1, 32'h0000_00FF, 1, 2'b00},
      '{REQ_CHECK,     0, 1'b0, 32'h0000_0000, 1, 2'b01},  // zero mask
      '{REQ_CHECK,     0, 1'b0, 32'h0000_0081, 1, 2'b01},
      '{REQ_CHECK,     0, 1'b0, 32'h0000_0100, 1, 2'b00},
      '{REQ_ADD_ENTRY, 1, 1'b0, 32'hFFFF_FFFF, 1, 2'b00},
      '{REQ_CHECK,     0, 1'b0, 32'h0000_0001, 1, 2'b00},  // deny wins
      '{REQ_ADD_ENTRY, 2, 1'b1, 32'hFFFF_FFFF, 0, 2'b00},
      '{REQ_IMPERSON,  2, 1'b0, 32'h0,         1, 2'b00},
      '{REQ_CHECK,     2, 1'b0, 32'hFFFF_FFFF, 0, 2'b00},
      '{REQ_SET_USER,  3, 1'b0, 32'h0,         1, 2'b00},  // impersonation stays
      '{REQ_CHECK,     2, 1'b0, 32'h8000_0000, 0, 2'b00},
      '{REQ_REVERT,    0, 1'b0, 32'h0,         1, 2'b00},
      '{REQ_CLEAR,     0, 1'b0, 32'h0,         1, 2'b00},
      '{REQ_ADD_ENTRY, 3, 1'b1, 32'hFFFF_FFFF, 0, 2'b00},
      '{REQ_CHECK,     3, 1'b0, 32'hFFFF_FFFF, 0, 2'b00},
      '{REQ_ADD_GROUP, 2, 1'b0, 32'h0,         0, 2'b00},
      '{REQ_CHECK,     2, 1'b0, 32'h0000_FFFF, 0, 2'b00},
      '{REQ_CLEAR,     0, 1'b0, 32'h0,         1, 2'b00}
   };

   function automatic sid_type row_sid(int kind);
      sid_type s;
      case (kind)
         0: s = default_sid(UserSub0);
         1: s = default_sid(GroupSub0);
         2: begin
            s.head = '1;
            for (int i = 0; i < NumSubs; i++) s.subs[i] = '1;
         end
         default: begin
            s.head = '0;
            for (int i = 0; i < NumSubs; i++) s.subs[i] = '0;
         end
      endcase
      return s;
   endfunction

   // drop valid and hold off until every verdict is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   initial begin
      access_req_type r;
      errors     = 0;
      cycles     = 0;
      accepted   = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      for (int i = 0; i < 4; i++) sub_pool[i] = $urandom;
      reset_token();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (rows[i]) begin
         r.code  = rows[i].code;
         r.sid   = row_sid(rows[i].sid_kind);
         r.allow = rows[i].allow;
         r.mask  = rows[i].mask;
         send_request(r, rows[i].typed, rows[i].want);
      end

      // fill table and group list past full
      for (int i = 0; i < NumEntries + 1; i++) begin
         r = random_request();
         r.code = REQ_ADD_ENTRY;
         send_request(r, (i == NumEntries), 2'b10);
      end
      for (int i = 0; i < NumGroups; i++) begin
         r = random_request();
         r.code = REQ_ADD_GROUP;
         send_request(r, (i == NumGroups - 1), 2'b10);
      end

      // hold off until every verdict is back
      wait_drained();

      for (int n = 0; n < 1100; n++) begin
         send_request(random_request(), 0, 2'b00);
         if (n == 550) wait_drained();
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
